// File: hdl/calrc_pkg.sv
package calrc_pkg;

  localparam int unsigned ProfileBytesDef = 22;
  localparam int unsigned ProfileBytesMax = 24;

  localparam logic [31:0] SumSeed    = 32'h1357_2468;
  localparam logic [31:0] RecMagic   = 32'h434F_4E42;
  localparam logic [15:0] RecVersion = 16'd1;
  localparam logic [7:0]  RecMark    = 8'hA0;
  localparam int unsigned SumRot     = 5;

  // record offsets
  localparam logic [5:0] PosMagicEnd   = 6'd3;
  localparam logic [5:0] PosVersionEnd = 6'd5;
  localparam logic [5:0] PosLengthEnd  = 6'd7;
  localparam logic [5:0] PosMark       = 6'd8;
  localparam logic [5:0] PosStatus     = 6'd9;
  localparam logic [5:0] PosPayStart   = 6'd12;
  localparam logic [5:0] PosSumEnd     = 6'd36;
  localparam logic [5:0] PosLast       = 6'd39;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } calrc_state_e;

  // end-of-record summary from the parser
  typedef struct packed {
    logic done;
    logic ok;
  } calrc_done_t;

  function automatic logic [31:0] sum_step(logic [31:0] sum, logic [7:0] b);
    logic [31:0] rot;
    rot = {sum[31-SumRot:0], sum[31:32-SumRot]};
    return rot + {24'd0, b};
  endfunction

endpackage

// File: hdl/calrc_store.sv
module calrc_store import calrc_pkg::*; #(
  parameter int unsigned PROFILE_BYTES = ProfileBytesDef,
  parameter int unsigned AW = (PROFILE_BYTES > 1) ? $clog2(PROFILE_BYTES) : 1
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [PROFILE_BYTES];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/calrc_parse.sv
module calrc_parse import calrc_pkg::*; #(
  parameter int unsigned PROFILE_BYTES = ProfileBytesDef,
  parameter int unsigned AW = (PROFILE_BYTES > 1) ? $clog2(PROFILE_BYTES) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    byte_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [7:0]    wr_data_o,
  output logic [7:0]    status_o,
  output calrc_done_t   done_o
);

  localparam logic [5:0] PayEnd = PosPayStart + 6'(PROFILE_BYTES);

  logic [5:0]  pos_q, pos_d;
  logic [31:0] sum_q, sum_d;
  logic [31:0] shift_q, shift_d;
  logic        ok_q, ok_d;
  logic [7:0]  status_q;
  logic [5:0]  pay_off;

  always_comb begin
    shift_d = {byte_i, shift_q[31:8]};
    sum_d   = (pos_q < PosSumEnd) ? sum_step(sum_q, byte_i) : sum_q;
    ok_d    = ok_q;
    if (pos_q == PosMagicEnd && shift_d != RecMagic) ok_d = 1'b0;
    if (pos_q == PosVersionEnd && shift_d[31:16] != RecVersion) ok_d = 1'b0;
    if (pos_q == PosLengthEnd && shift_d[31:16] != 16'(PROFILE_BYTES)) ok_d = 1'b0;
    if (pos_q == PosMark && byte_i != RecMark) ok_d = 1'b0;
    pos_d = pos_q + 6'd1;
  end

  assign pay_off   = pos_q - PosPayStart;
  assign wr_en_o   = accept_i && (pos_q >= PosPayStart) && (pos_q < PayEnd);
  assign wr_addr_o = pay_off[AW-1:0];
  assign wr_data_o = byte_i;
  assign status_o  = status_q;

  assign done_o.done = accept_i && (pos_q == PosLast);
  assign done_o.ok   = ok_d && (shift_d == sum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sum_q    <= SumSeed;
      shift_q  <= '0;
      ok_q     <= 1'b1;
      status_q <= '0;
    end else if (accept_i) begin
      if (pos_q == PosStatus) status_q <= byte_i;
      if (pos_q == PosLast) begin
        pos_q   <= '0;
        sum_q   <= SumSeed;
        shift_q <= '0;
        ok_q    <= 1'b1;
      end else begin
        pos_q   <= pos_d;
        sum_q   <= sum_d;
        shift_q <= shift_d;
        ok_q    <= ok_d;
      end
    end
  end

endmodule

// File: hdl/calibration_record_checker_top.sv
// Checks a 40-byte calibration record taken one byte per cycle (magic word,
// version, payload length, marker byte and a rotate-and-add checksum over
// bytes 0..35) and keeps the status byte in a register and the payload
// bytes in a small on-chip buffer. Record bytes are taken every cycle while
// no results are pending. After byte 40 the input stalls while the results
// drain: either PROFILE_BYTES transactions carrying the status and one
// payload byte each, or a single invalid transaction. The burst runs at one
// transaction per cycle while out_ready_i is high; the buffer is read ahead,
// so the first payload byte is ready when the burst starts. There is no
// resynchronization: every 40 input transactions after reset form a record.
module calibration_record_checker_top import calrc_pkg::*; #(
  parameter int unsigned PROFILE_BYTES = ProfileBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] record_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o,
  output logic [7:0] cal_status_o,
  output logic [7:0] payload_byte_o,
  output logic       last_o
);

  localparam int unsigned AW = (PROFILE_BYTES > 1) ? $clog2(PROFILE_BYTES) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(PROFILE_BYTES - 1);

  calrc_state_e  state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          res_ok_q, res_ok_d;
  logic [AW-1:0] rd_addr;
  logic          in_fire, out_fire, is_last;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data, rd_data, status;
  calrc_done_t   done;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  calrc_parse #(.PROFILE_BYTES(PROFILE_BYTES), .AW(AW)) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_fire),
    .byte_i   (record_byte_i),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .wr_data_o(wr_data),
    .status_o (status),
    .done_o   (done)
  );

  calrc_store #(.PROFILE_BYTES(PROFILE_BYTES), .AW(AW)) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign is_last = !res_ok_q || (idx_q == LastIdx);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    res_ok_d    = res_ok_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    // read address tracks the entry shown next cycle; holds while stalled
    rd_addr     = idx_q;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        rd_addr    = '0;
        if (done.done) begin
          state_d  = ST_EMIT;
          idx_d    = '0;
          res_ok_d = done.ok;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_fire) begin
          if (is_last) begin
            state_d = ST_LOAD;
            idx_d   = '0;
            rd_addr = '0;
          end else begin
            idx_d   = idx_q + AW'(1);
            rd_addr = idx_d;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      idx_q    <= '0;
      res_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      res_ok_q <= res_ok_d;
    end
  end

  assign valid_res_o    = res_ok_q;
  assign cal_status_o   = res_ok_q ? status : 8'd0;
  assign payload_byte_o = res_ok_q ? rd_data : 8'd0;
  assign last_o         = is_last;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted during result burst");

  a_invalid_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (last_o && payload_byte_o == 8'd0
                                       && cal_status_o == 8'd0))
    else $error("invalid result not a single zeroed transaction");

  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> (in_ready_o && !out_valid_o))
    else $error("burst did not end after last");

  a_burst_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(idx_q)))
    else $error("result index moved while stalled");

endmodule
